FILE: sv/uvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int CAP_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int COUNT_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_READ,
    OP_NOP
  } uvs_op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_DUP,
    ST_FULL,
    ST_POP_EMPTY,
    ST_INDEX,
    ST_READ_EMPTY
  } uvs_status_t;

  typedef enum logic [1:0] {
    UVS_IDLE,
    UVS_EVAL,
    UVS_HOLD
  } uvs_state_t;

  typedef struct packed {
    uvs_op_t            opcode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position_in;
  } uvs_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] data_out;
    uvs_status_t        status;
    logic [COUNT_W-1:0] count;
  } uvs_out_t;

  typedef struct packed {
    logic    look;
    logic    wr;
    uvs_op_t op;
  } uvs_ctl_t;

endpackage

`default_nettype wire

FILE: sv/unique_value_stack_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                              | Direction | Payload
// input   | in_valid, in_ready, in_data        | in        | uvs_in_t (opcode, value, position_in)
// result  | out_valid, out_ready, out_data     | out       | uvs_out_t (data_out, status, count)
// config  | cfg_valid, cfg_ready, cfg_data     | in        | capacity, 5 bits (always ready)
//
// Each transaction runs as follows: the accept edge latches compare and pick flags
// in every cell, the next cycle reduces them across the row and updates the stack.
// The result is held until taken; the next transaction is accepted in that same cycle,
// so a new transaction is never accepted before the previous result is taken.
// Reset (synchronous) clears every cell to zero, the count to zero and capacity to 16.
// A stalled result blocks the input channel.

module unique_value_stack_top #(
  parameter int DEPTH  = uvs_pkg::DEPTH_DEF,
  parameter int DATA_W = uvs_pkg::DATA_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire uvs_pkg::uvs_in_t           in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output uvs_pkg::uvs_out_t               out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [uvs_pkg::CAP_W-1:0]  cfg_data
);
  import uvs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  uvs_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  uvs_out_t           out_r, out_nxt;
  logic [CAP_W-1:0]   cap_r;
  uvs_op_t            op_r;
  logic [DATA_W-1:0]  value_r;
  logic [POS_W-1:0]   pos_r;

  logic               in_fire;
  logic               push_ok;
  uvs_ctl_t           ctl;
  logic [DATA_W-1:0]  in_value;
  logic [CNT_W-1:0]   eff_cap;
  logic [CW-1:0]      cap_w;

  logic [DEPTH-1:0]   dup_vec;
  logic [DEPTH-1:0]   pick_vec;
  logic [DATA_W-1:0]  pick_data [DEPTH];
  logic               dup_any;
  logic [DATA_W-1:0]  picked;

  assign in_value  = DATA_W'(in_data.value);
  assign in_ready  = (state_r == UVS_IDLE) || ((state_r == UVS_HOLD) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == UVS_HOLD);
  assign out_data  = out_r;

  always_comb begin
    ctl.look = in_fire;
    ctl.wr   = push_ok;
    ctl.op   = in_data.opcode;
  end

  always_comb begin
    cap_w = CW'(cap_r);
    if (cap_w == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_w > CW'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_w);
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    uvs_cell #(
      .DATA_W (DATA_W),
      .CNT_W  (CNT_W),
      .INDEX  (k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cmp_data    (in_value),
      .wr_data     (value_r),
      .count       (count_r),
      .pos         (in_data.position_in),
      .dup_o       (dup_vec[k]),
      .pick_o      (pick_vec[k]),
      .pick_data_o (pick_data[k])
    );
  end

  always_comb begin
    picked = '0;
    for (int k = 0; k < DEPTH; k++) begin
      picked = picked | pick_data[k];
    end
  end

  assign dup_any = |dup_vec;

  always_comb begin
    push_ok   = 1'b0;
    count_nxt = count_r;
    out_nxt   = out_r;
    state_nxt = state_r;
    if (state_r == UVS_EVAL) begin
      out_nxt.data_out = '0;
      out_nxt.status   = ST_OK;
      case (op_r)
        OP_PUSH: begin
          if (dup_any) begin
            out_nxt.status = ST_DUP;
          end else if (count_r >= eff_cap) begin
            out_nxt.status = ST_FULL;
          end else begin
            push_ok   = 1'b1;
            count_nxt = CNT_W'(count_r + CNT_W'(1));
          end
        end
        OP_POP: begin
          if (count_r == '0) begin
            out_nxt.status = ST_POP_EMPTY;
          end else begin
            count_nxt        = CNT_W'(count_r - CNT_W'(1));
            out_nxt.data_out = VALUE_W'(picked);
          end
        end
        OP_READ: begin
          if (PW'(pos_r) >= PW'(eff_cap)) begin
            out_nxt.status = ST_INDEX;
          end else if (count_r == '0) begin
            out_nxt.status = ST_READ_EMPTY;
          end else begin
            out_nxt.data_out = VALUE_W'(picked);
          end
        end
        default: begin
        end
      endcase
      out_nxt.count = COUNT_W'(count_nxt);
    end
    case (state_r)
      UVS_IDLE: begin
        if (in_fire) begin
          state_nxt = UVS_EVAL;
        end
      end
      UVS_EVAL: begin
        state_nxt = UVS_HOLD;
      end
      UVS_HOLD: begin
        if (out_ready) begin
          state_nxt = in_valid ? UVS_EVAL : UVS_IDLE;
        end
      end
      default: begin
        state_nxt = UVS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= UVS_IDLE;
      count_r <= '0;
      cap_r   <= CAP_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_fire) begin
      op_r    <= in_data.opcode;
      value_r <= in_value;
      pos_r   <= in_data.position_in;
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_pick_single : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == UVS_EVAL) |-> $onehot0(pick_vec))
    else $error("more than one cell picked");

  a_dup_holds_count : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == UVS_EVAL) && (op_r == OP_PUSH) && dup_any) |=> (count_r == $past(count_r)))
    else $error("duplicate push changed count");

  a_accept_evals : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == UVS_EVAL))
    else $error("accepted transaction not evaluated");

endmodule

`default_nettype wire

FILE: sv/uvs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module uvs_cell #(
  parameter int DATA_W = 32,
  parameter int CNT_W  = 5,
  parameter int INDEX  = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire uvs_pkg::uvs_ctl_t          ctl,
  input  wire logic [DATA_W-1:0]          cmp_data,
  input  wire logic [DATA_W-1:0]          wr_data,
  input  wire logic [CNT_W-1:0]           count,
  input  wire logic [uvs_pkg::POS_W-1:0]  pos,
  output logic                            dup_o,
  output logic                            pick_o,
  output logic [DATA_W-1:0]               pick_data_o
);
  import uvs_pkg::*;

  localparam int KW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [KW-1:0] K = KW'(INDEX);

  logic [DATA_W-1:0] entry_r;
  logic              dup_r;
  logic              pick_r;
  logic [DATA_W-1:0] pick_data_r;
  logic [KW-1:0]     count_k;
  logic [KW-1:0]     pos_k;
  logic              live;
  logic              sel;

  always_comb begin
    count_k = KW'(count);
    pos_k   = KW'(pos);
    live    = K < count_k;
    sel     = ((ctl.op == OP_READ) && (K == pos_k)) ||
              ((ctl.op == OP_POP) && (count_k != '0) && (K == KW'(count_k - KW'(1))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r     <= '0;
      dup_r       <= 1'b0;
      pick_r      <= 1'b0;
      pick_data_r <= '0;
    end else begin
      if (ctl.wr && (K == count_k)) begin
        entry_r <= wr_data;
      end
      if (ctl.look) begin
        dup_r       <= live && (entry_r == cmp_data);
        pick_r      <= sel;
        pick_data_r <= sel ? entry_r : '0;
      end
    end
  end

  assign dup_o       = dup_r;
  assign pick_o      = pick_r;
  assign pick_data_o = pick_data_r;

endmodule

`default_nettype wire

FILE: dv/uvs_checker.sv
`timescale 1ns / 1ps

module uvs_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  uvs_pkg::uvs_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  uvs_pkg::uvs_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [uvs_pkg::CAP_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        n_checked
);
  import uvs_pkg::*;

  localparam int SLOTS = DEPTH_DEF;

  logic [VALUE_W-1:0] stack_mem [SLOTS];
  int                 stack_used;
  logic [CAP_W-1:0]   cap_reg;
  uvs_out_t           owed_results [$];
  int                 errs;
  int                 checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    n_checked  = 0;
    errs       = 0;
    checked    = 0;
    stack_used = 0;
    cap_reg    = CAP_RST;
    foreach (stack_mem[k]) stack_mem[k] = '0;
  end

  function automatic uvs_out_t predict_stack_op(uvs_in_t t);
    uvs_out_t r;
    int       lim;
    bit       hit;
    r.data_out = '0;
    r.status   = ST_OK;
    hit        = 1'b0;
    lim        = (cap_reg == 0) ? 1 : (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
    case (t.opcode)
      OP_PUSH: begin
        for (int k = 0; k < stack_used; k++)
          if (stack_mem[k] == t.value) hit = 1'b1;
        if (hit) begin
          r.status = ST_DUP;
        end else if (stack_used >= lim) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_used] = t.value;
          stack_used++;
        end
      end
      OP_POP: begin
        if (stack_used == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          stack_used--;
          r.data_out = stack_mem[stack_used];
        end
      end
      OP_READ: begin
        if (int'(t.position_in) >= lim) begin
          r.status = ST_INDEX;
        end else if (stack_used == 0) begin
          r.status = ST_READ_EMPTY;
        end else begin
          r.data_out = stack_mem[t.position_in];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(stack_used);
    return r;
  endfunction

  task automatic flag_error(string msg);
    errs++;
    if (errs <= 10) $display("[%0t] result error: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    uvs_out_t want;
    if (!rst_n) begin
      foreach (stack_mem[k]) stack_mem[k] = '0;
      stack_used = 0;
      cap_reg    = CAP_RST;
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (in_valid && in_ready) owed_results.push_back(predict_stack_op(in_data));
      if (out_valid && out_ready) begin
        checked++;
        if (owed_results.size() == 0) begin
          flag_error($sformatf("unexpected result data=%h status=%0d count=%0d",
                               out_data.data_out, int'(out_data.status), out_data.count));
        end else begin
          want = owed_results.pop_front();
          if (out_data.data_out !== want.data_out || out_data.status !== want.status ||
              out_data.count !== want.count)
            flag_error($sformatf("exp data=%h st=%0d cnt=%0d, got data=%h st=%0d cnt=%0d",
                                 want.data_out, int'(want.status), want.count,
                                 out_data.data_out, int'(out_data.status), out_data.count));
        end
      end
    end
    pending    <= owed_results.size();
    fail_count <= errs;
    n_checked  <= checked;
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import uvs_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  uvs_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  uvs_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  int               fail_count;
  int               pending;
  int               n_checked;

  bit               no_gaps = 1'b0;
  int               op_hits [4];
  int               cap_writes = 0;
  logic [31:0]      val_pool [8];

  always #4 clk = ~clk;

  unique_value_stack_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  uvs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_checked  (n_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic uvs_op_t pick_op(bit drain);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_NOP;
    if (r < 20) return OP_READ;
    if (drain ? (r < 80) : (r < 40)) return OP_POP;
    return OP_PUSH;
  endfunction

  task automatic send_txn(uvs_op_t op, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
    uvs_in_t t;
    int      gap;
    t.opcode      = op;
    t.value       = v;
    t.position_in = p;
    gap           = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    op_hits[int'(op)]++;
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // receiver: random stalls plus one long hold-off to back up the input
  initial begin
    int  taken;
    int  stall_left;
    int  gap;
    bit  held;
    taken      = 0;
    stall_left = 0;
    held       = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && taken >= 250) begin
        held       = 1'b1;
        stall_left = 120;
        out_ready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] cap_plan [6];
    logic [CAP_W-1:0] cap;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0] p;
    cap_plan = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd17};
    foreach (op_hits[k]) op_hits[k] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_txn(OP_POP, '1, '0);
    send_txn(OP_READ, '0, 8'd0);
    send_txn(OP_READ, '0, 8'd255);
    send_txn(OP_READ, '0, 8'd16);
    send_txn(OP_NOP, '1, '1);
    send_txn(OP_PUSH, '0, '0);
    send_txn(OP_PUSH, '0, '0);
    send_txn(OP_PUSH, '1, '0);
    send_txn(OP_PUSH, 32'hA5A5_5A5A, '0);
    send_txn(OP_READ, '0, 8'd15);
    send_txn(OP_READ, '0, 8'd1);
    send_txn(OP_POP, '0, '0);
    send_txn(OP_READ, '0, 8'd2);
    send_txn(OP_PUSH, 32'h5A5A_A5A5, '0);
    set_capacity(5'd2);
    send_txn(OP_PUSH, 32'h1234_5678, '0);
    send_txn(OP_PUSH, '0, '0);
    send_txn(OP_READ, '0, 8'd2);
    send_txn(OP_READ, '0, 8'd1);
    send_txn(OP_POP, '0, '0);
    send_txn(OP_PUSH, 32'h8765_4321, '0);
    set_capacity(5'd0);
    send_txn(OP_POP, '0, '0);
    send_txn(OP_PUSH, 32'h0F0F_0F0F, '0);
    send_txn(OP_READ, '0, 8'd1);
    set_capacity(5'd31);
    send_txn(OP_READ, '0, 8'd15);
    send_txn(OP_POP, '0, '0);
    send_txn(OP_POP, '0, '0);

    for (int ph = 0; ph < 10; ph++) begin
      cap = (ph < 6) ? cap_plan[ph] : CAP_W'($urandom_range(0, 31));
      set_capacity(cap);
      no_gaps = (ph == 4);
      val_pool[0] = '0;
      val_pool[1] = '1;
      for (int k = 2; k < 8; k++) val_pool[k] = $urandom();
      for (int i = 0; i < 105; i++) begin
        v = $urandom_range(0, 1) ? val_pool[$urandom_range(0, 7)] : VALUE_W'($urandom());
        p = ($urandom_range(0, 99) < 75) ? POS_W'($urandom_range(0, 16))
                                         : POS_W'($urandom_range(0, 255));
        send_txn(pick_op(((i / 24) % 2) == 1), v, p);
      end
    end
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    $display("%0d transactions: %0d push, %0d pop, %0d read, %0d nop; %0d capacity writes",
             op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
             op_hits[0], op_hits[1], op_hits[2], op_hits[3], cap_writes);
    $display("%0d results compared against the predicted stack, %0d failures",
             n_checked, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: unique_value_stack_top.f
sv/uvs_pkg.sv
sv/uvs_cell.sv
sv/unique_value_stack_top.sv
dv/uvs_checker.sv
dv/tb.sv
